// ===== rtl/core/rpn_pkg.sv =====
// rpn_pkg: shared constants, command and status codes, and Q32.32 helpers
// for the RPN stack calculator core. No dependencies.
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 64;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PI   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_GCD  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_LCM  = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEG   = 3'd4;

  // 3.141592 in Q32.32, rounded to nearest
  localparam logic [DATA_W-1:0] PI_Q    = 64'd13493034897;
  localparam logic [DATA_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIM = 64'h8000_0000_0000_0000;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] from_sign_mag(input logic [DATA_W-1:0] mag,
                                                      input logic neg,
                                                      input logic big);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (big || mag > NEG_LIM) ? NEG_LIM : (~mag + 64'd1);
    end else begin
      r = (big || mag > POS_MAX) ? POS_MAX : mag;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] q_add(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = a + b;
    if (((a ^ r) & (b ^ r)) >> (DATA_W - 1) != '0) begin
      r = a[DATA_W-1] ? NEG_LIM : POS_MAX;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] q_sub(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = a - b;
    if (((a ^ b) & (a ^ r)) >> (DATA_W - 1) != '0) begin
      r = a[DATA_W-1] ? NEG_LIM : POS_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpn_ram.sv =====
// rpn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpn_stack_calculator_core.sv =====
// rpn_stack_calculator_core: RPN operand stack over signed Q32.32 numbers.
// Operations: push and pi, add/sub, mul and div (one bit a cycle through shift-add /
// shift-subtract steps on the shared a, b, c registers), gcd (binary Euclid),
// lcm (gcd, divide, multiply in sequence). One item at a time; a new
// item is taken while the previous result waits in the output register.
// Reset empties the stack. Depends on rpn_pkg and rpn_ram.
`default_nettype none

module rpn_stack_calculator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [rpn_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] operand_value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [rpn_pkg::STATUS_W-1:0]  status_o,
  output      logic signed [rpn_pkg::DATA_W-1:0] top_value_o,
  output      logic [rpn_pkg::COUNT_W-1:0]   stack_count_o
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_GFIX = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [DATA_W-1:0]   top_q, top_d;
  logic [DATA_W-1:0]   x_q, x_d;
  logic [DATA_W-1:0]   a_q, a_d, b_q, b_d, c_q, c_d;
  logic [DATA_W-1:0]   res_q, res_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic                neg_q, neg_d;
  logic [STATUS_W-1:0] st_q, st_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [DATA_W-1:0]   out_top_q, out_top_d;
  logic [COUNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic              accept, is_lcm;
  logic [DATA_W-1:0] mag_x, mag_y;
  logic [DATA_W:0]   mul_sum, div_sh, div_rem;
  logic              div_ge, gcd_ge;
  logic [DATA_W-1:0] gcd_diff, quo;
  logic [2*DATA_W-1:0] prod;

  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sp_m1      = sp_q - SP_W'(1);
  assign sp_m2      = sp_q - SP_W'(2);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_lcm     = (cmd_q == CMD_LCM);
  assign mag_x      = magnitude(ram_rdata);
  assign mag_y      = magnitude(top_q);

  // shift-add multiply step: c holds the high half, b the low half/multiplier
  assign mul_sum = {1'b0, c_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign prod    = {mul_sum[DATA_W:1], mul_sum[0], b_q[DATA_W-1:1]};
  // restoring divide step: c is the remainder, b shifts dividend out, quotient in
  assign div_sh  = {c_q, b_q[DATA_W-1]};
  assign div_ge  = (div_sh >= {1'b0, a_q});
  assign div_rem = div_sh - {1'b0, a_q};
  assign quo     = {b_q[DATA_W-2:0], div_ge};
  assign gcd_ge   = (a_q >= b_q);
  assign gcd_diff = gcd_ge ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    top_d       = top_q;
    x_d         = x_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    neg_d       = neg_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_top_d   = out_top_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = sp_q[AW-1:0];
    ram_wdata   = (cmd_i == CMD_PUSH) ? operand_value_i : PI_Q;
    ram_raddr   = sp_m2[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          if (cmd_i == CMD_PUSH || cmd_i == CMD_PI) begin
            if (sp_q >= SP_W'(STACK_DEPTH)) begin
              st_d = ST_OVER;
            end else begin
              ram_we = 1'b1;
              top_d  = ram_wdata;
              sp_d   = sp_q + SP_W'(1);
              st_d   = ST_OK;
            end
            state_d = S_DONE;
          end else if (sp_q < SP_W'(2)) begin
            st_d    = ST_UNDER;
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        x_d   = ram_rdata;
        neg_d = ram_rdata[DATA_W-1] ^ top_q[DATA_W-1];
        cnt_d = '0;
        st_d  = ST_OK;
        case (cmd_q) inside
          CMD_ADD: begin
            res_d   = q_add(ram_rdata, top_q);
            state_d = S_WB;
          end
          CMD_SUB: begin
            res_d   = q_sub(ram_rdata, top_q);
            state_d = S_WB;
          end
          CMD_MUL: begin
            a_d     = mag_y;
            b_d     = mag_x;
            c_d     = '0;
            state_d = S_MUL;
          end
          CMD_DIV: begin
            if (top_q == '0) begin
              st_d    = ST_DIVZ;
              state_d = S_DONE;
            end else if ({32'd0, mag_x[DATA_W-1:32]} >= mag_y) begin
              res_d   = from_sign_mag('0, ram_rdata[DATA_W-1] ^ top_q[DATA_W-1], 1'b1);
              state_d = S_WB;
            end else begin
              a_d     = mag_y;
              c_d     = {32'd0, mag_x[DATA_W-1:32]};
              b_d     = {mag_x[31:0], 32'd0};
              state_d = S_DIV;
            end
          end
          CMD_GCD, CMD_LCM: begin
            if (ram_rdata[DATA_W-1] || top_q[DATA_W-1]) begin
              st_d    = ST_NEG;
              state_d = S_DONE;
            end else begin
              a_d     = ram_rdata;
              b_d     = top_q;
              state_d = S_GCD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MUL: begin
        c_d   = mul_sum[DATA_W:1];
        b_d   = {mul_sum[0], b_q[DATA_W-1:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          if (is_lcm) begin
            res_d = (prod[2*DATA_W-1:DATA_W-1] != '0) ? POS_MAX : prod[DATA_W-1:0];
          end else begin
            res_d = from_sign_mag(prod[95:32], neg_q, prod[127:96] != '0);
          end
          state_d = S_WB;
        end
      end
      S_DIV: begin
        c_d   = div_ge ? div_rem[DATA_W-1:0] : div_sh[DATA_W-1:0];
        b_d   = quo;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          if (is_lcm) begin
            // lcm: quotient x/g times y
            a_d     = top_q;
            c_d     = '0;
            state_d = S_MUL;
          end else begin
            res_d   = from_sign_mag(quo, neg_q, 1'b0);
            state_d = S_WB;
          end
        end
      end
      S_GCD: begin
        // binary Euclid; cnt counts common factors of two
        if (a_q == '0) begin
          a_d     = b_q;
          state_d = S_GFIX;
        end else if (b_q == '0) begin
          state_d = S_GFIX;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d   = a_q >> 1;
          b_d   = b_q >> 1;
          cnt_d = cnt_q + 6'd1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (gcd_ge) begin
          a_d = gcd_diff >> 1;
        end else begin
          b_d = gcd_diff >> 1;
        end
      end
      S_GFIX: begin
        if (cnt_q == '0) begin
          if (!is_lcm) begin
            res_d   = a_q;
            state_d = S_WB;
          end else if (a_q == '0) begin
            st_d    = ST_DIVZ;
            state_d = S_DONE;
          end else begin
            b_d     = x_q;
            c_d     = '0;
            state_d = S_DIV;
          end
        end else begin
          a_d   = a_q << 1;
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = sp_m2[AW-1:0];
        ram_wdata = res_q;
        top_d     = res_q;
        sp_d      = sp_m1;
        st_d      = ST_OK;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_top_d   = (sp_q == '0) ? '0 : top_q;
          out_cnt_d   = COUNT_W'(sp_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    x_q       <= x_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    cmd_q     <= cmd_d;
    neg_q     <= neg_d;
    st_q      <= st_d;
    out_st_q  <= out_st_d;
    out_top_q <= out_top_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign top_value_o   = out_top_q;
  assign stack_count_o = out_cnt_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVER |-> stack_count_o == COUNT_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_under_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDER |-> stack_count_o < COUNT_W'(2))
    else $error("underflow reported with two or more entries");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stack_count_o == '0 |-> top_value_o == '0)
    else $error("nonzero top on an empty stack");

  a_wb_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |=> sp_q == $past(sp_q) - SP_W'(1))
    else $error("operation result did not replace two entries");

endmodule

`default_nettype wire
